@@ rtl/core/itrd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared constants, register indexes and the digit table lookup for the
// integer to radix digits converter.
// ----------------------------------------------------------------------------
package itrd_pkg;

  localparam int VALUE_W    = 32;
  localparam int RADIX_W    = 5;
  localparam int CHAR_W     = 8;
  localparam int TABLE_W    = 64;
  localparam int CFG_IDX_W  = 2;

  // quotient bits retired per cycle by the shared divide step
  localparam int STEP_BITS       = 8;
  localparam int STEPS_PER_DIGIT = VALUE_W / STEP_BITS;
  localparam int STEP_CNT_W      = $clog2(STEPS_PER_DIGIT);

  localparam logic [CFG_IDX_W-1:0] REG_RADIX     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_RESET      = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN        = 5'd2;
  localparam logic [TABLE_W-1:0] CHARS_LOW_RESET  = 64'h3736353433323130;
  localparam logic [TABLE_W-1:0] CHARS_HIGH_RESET = 64'h4645444342413938;
  localparam logic [CHAR_W-1:0]  ZERO_CHAR        = 8'h30;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [RADIX_W-1:0] radix_t;
  typedef logic [CHAR_W-1:0]  char_t;

  // character for one digit; digits past the sixteen table slots give zero
  function automatic char_t digit_symbol(input radix_t d,
                                         input logic [TABLE_W-1:0] lo,
                                         input logic [TABLE_W-1:0] hi);
    logic [TABLE_W-1:0] sel;
    char_t              c;
    sel = d[3] ? hi : lo;
    sel = sel >> {d[2:0], 3'b000};
    c   = (d[4] == 1'b1) ? '0 : sel[CHAR_W-1:0];
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/integer_to_radix_digits.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts a 32-bit value into digit characters of a configurable radix.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with value_bits and is_signed while busy is low; the item is
//   taken on that edge. The characters come back most significant first on
//   digit_char, one per cycle while result_strobe is high, with negative set
//   on each of them for a negative signed value and last on the final one.
//   A zero value gives a single '0' in the cycle after start.
//   Timing: the shared divide unit retires 8 quotient bits a cycle. All
//   digits are computed before the first character appears, and the
//   characters then follow back to back.
//   At most MAX_DIGITS characters are produced, the least significant ones.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data)
//   always accepts; write it only while busy is low and no strobe is due.
//   Radix values below 2 act as 2, values above MAX_RADIX as MAX_RADIX.
//   Reset restores radix 10 and the table "0123456789ABCDEF" and drops any
//   item in flight; there is no clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
module integer_to_radix_digits
  import itrd_pkg::*;
#(
  parameter int MAX_DIGITS = 32,
  parameter int MAX_RADIX  = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  wire value_t          value_bits,
  input  wire                  is_signed,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [TABLE_W-1:0]    cfg_data,
  output logic                 result_strobe,
  output char_t                digit_char,
  output logic                 negative,
  output logic                 last
);

  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW = $clog2(MAX_DIGITS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]             state;
  radix_t                 radix;
  logic [TABLE_W-1:0]     digit_chars_low;
  logic [TABLE_W-1:0]     digit_chars_high;
  radix_t                 base;
  radix_t                 base_next;
  value_t                 quot;
  radix_t                 rem;
  value_t                 quot_next;
  radix_t                 rem_next;
  logic [STEP_CNT_W-1:0]  step_cnt;
  logic [CW-1:0]          cnt;
  logic [CW-1:0]          cnt_inc;
  logic [AW-1:0]          ptr;
  logic                   zero_sel;
  value_t                 mag;
  logic                   neg_in;
  logic                   accept;
  logic                   digit_done;
  logic                   rd_en;
  char_t                  rd_data;
  char_t                  sym;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign neg_in    = is_signed && value_bits[VALUE_W-1];
  assign mag       = neg_in ? (VALUE_W'(0) - value_bits) : value_bits;

  always_comb begin
    if (radix < RADIX_MIN) begin
      base_next = RADIX_MIN;
    end else if (32'(radix) > MAX_RADIX) begin
      base_next = RADIX_W'(MAX_RADIX);
    end else begin
      base_next = radix;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radix            <= RADIX_RESET;
      digit_chars_low  <= CHARS_LOW_RESET;
      digit_chars_high <= CHARS_HIGH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RADIX:      radix            <= cfg_data[RADIX_W-1:0];
        REG_CHARS_LOW:  digit_chars_low  <= cfg_data;
        REG_CHARS_HIGH: digit_chars_high <= cfg_data;
        default: ;
      endcase
    end
  end

  itrd_divstep u_divstep (
    .quot_in  (quot),
    .rem_in   (rem),
    .base     (base),
    .quot_out (quot_next),
    .rem_out  (rem_next)
  );

  assign digit_done = (state == S_DIV) && (step_cnt == STEP_CNT_W'(STEPS_PER_DIGIT - 1));
  assign cnt_inc    = cnt + CW'(1);
  assign sym        = digit_symbol(rem_next, digit_chars_low, digit_chars_high);
  assign rd_en      = (state == S_EMIT);

  itrd_digit_buf #(
    .DEPTH (MAX_DIGITS),
    .AW    (AW)
  ) u_digit_buf (
    .clk     (clk),
    .wr_en   (digit_done),
    .wr_addr (cnt[AW-1:0]),
    .wr_data (sym),
    .rd_en   (rd_en),
    .rd_addr (ptr),
    .rd_data (rd_data)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_strobe <= 1'b0;
      last          <= 1'b0;
      zero_sel      <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      last          <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (mag == '0) begin
              result_strobe <= 1'b1;
              last          <= 1'b1;
              zero_sel      <= 1'b1;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (digit_done && ((quot_next == '0) || (cnt_inc == CW'(MAX_DIGITS)))) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          result_strobe <= 1'b1;
          zero_sel      <= 1'b0;
          if (ptr == '0) begin
            last  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          quot     <= mag;
          rem      <= '0;
          base     <= base_next;
          step_cnt <= '0;
          cnt      <= '0;
          negative <= neg_in;
        end
      end
      S_DIV: begin
        quot     <= quot_next;
        step_cnt <= step_cnt + STEP_CNT_W'(1);
        if (digit_done) begin
          rem <= '0;
          cnt <= cnt_inc;
          ptr <= cnt[AW-1:0];
        end else begin
          rem <= rem_next;
        end
      end
      S_EMIT: begin
        ptr <= ptr - AW'(1);
      end
      default: ;
    endcase
  end

  assign digit_char = zero_sel ? ZERO_CHAR : rd_data;

`ifndef SYNTHESIS
  a_start_response: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || (result_strobe && last)))
    else $error("accepted item produced neither work nor a result");

  a_emit_contiguous: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !last) |=> result_strobe)
    else $error("character stream broke before last");

  a_done_with_last: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> (result_strobe && last))
    else $error("conversion ended without a last character");

  a_zero_single: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && zero_sel) |-> (last && !negative && !busy))
    else $error("zero value result malformed");
`endif

endmodule
`default_nettype wire

@@ rtl/core/itrd_divstep.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itrd_divstep
// Shared restoring divide unit: retires STEP_BITS quotient bits of a
// 32-bit value divided by a narrow radix in one pass.
// ----------------------------------------------------------------------------
module itrd_divstep
  import itrd_pkg::*;
(
  input  wire value_t quot_in,
  input  wire radix_t rem_in,
  input  wire radix_t base,
  output value_t      quot_out,
  output radix_t      rem_out
);

  always_comb begin
    logic [RADIX_W:0]   trial;
    value_t             q;
    radix_t             r;
    q = quot_in;
    r = rem_in;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {r, q[VALUE_W-1]};
      q     = {q[VALUE_W-2:0], 1'b0};
      if (trial >= {1'b0, base}) begin
        trial = trial - {1'b0, base};
        q[0]  = 1'b1;
      end
      r = trial[RADIX_W-1:0];
    end
    quot_out = q;
    rem_out  = r;
  end

endmodule
`default_nettype wire

@@ rtl/core/itrd_digit_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itrd_digit_buf
// Digit character store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module itrd_digit_buf
  import itrd_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire          clk,
  input  wire          wr_en,
  input  wire [AW-1:0] wr_addr,
  input  wire char_t   wr_data,
  input  wire          rd_en,
  input  wire [AW-1:0] rd_addr,
  output char_t        rd_data
);

  char_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
